@@ sv/date_day_number_arithmetic_unit_assert.svh @@
// Assertion macros for the date shifter checker.
`ifndef DATE_DAY_NUMBER_ARITHMETIC_UNIT_ASSERT_SVH
`define DATE_DAY_NUMBER_ARITHMETIC_UNIT_ASSERT_SVH

// pre holds -> post holds in the next cycle
`define DDAU_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("ddau: next-cycle check failed");

// pre holds -> post holds in the same cycle
`define DDAU_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("ddau: same-cycle check failed");

// checked across reset: the cycle after reset is low
`define DDAU_ASSERT_RESET(label, clk, rst_n, post) \
    label: assert property (@(posedge clk) (!rst_n) |=> (post)) \
        else $error("ddau: reset check failed");

`endif

@@ sv/ddau_pkg.sv @@
`default_nettype none

package ddau_pkg;

    localparam int BASE_YEAR  = 1900;
    localparam int GREG_START = 1583;
    localparam int YEAR_SPAN  = 256;

    localparam int YOFF_W = (YEAR_SPAN > 1) ? $clog2(YEAR_SPAN) : 1;
    localparam int SRCH_W = (YOFF_W > 4) ? YOFF_W : 4;
    localparam int BIT_W  = $clog2(SRCH_W);

    localparam int DAY_W  = 5;
    localparam int MON_W  = 4;
    localparam int YEAR_W = 12;
    localparam int AMT_W  = 16;
    localparam int UNIT_W = 2;
    localparam int DN_W   = 17;
    localparam int CUM_W  = 9;
    localparam int ACC_W  = 22;
    localparam int NY_W   = 18;

    // s_tdata field positions
    localparam int DAY_LSB   = 0;
    localparam int MON_LSB   = DAY_LSB + DAY_W;
    localparam int YEAR_LSB  = MON_LSB + MON_W;
    localparam int SUB_LSB   = YEAR_LSB + YEAR_W;
    localparam int AMT_LSB   = SUB_LSB + 1;
    localparam int S_TDATA_W = ((AMT_LSB + AMT_W + 7) / 8) * 8;

    // m_tdata field positions
    localparam int DN_LSB    = 0;
    localparam int NDAY_LSB  = DN_LSB + DN_W;
    localparam int NMON_LSB  = NDAY_LSB + DAY_W;
    localparam int NYEAR_LSB = NMON_LSB + MON_W;
    localparam int M_TDATA_W = ((NYEAR_LSB + YEAR_W + 7) / 8) * 8;

    localparam logic [YEAR_W-1:0] FIRST_YEAR = YEAR_W'(BASE_YEAR);
    localparam logic [YEAR_W-1:0] LAST_YEAR  = YEAR_W'(BASE_YEAR + YEAR_SPAN - 1);

    localparam logic [UNIT_W-1:0] UNIT_DAYS  = 2'd0;
    localparam logic [UNIT_W-1:0] UNIT_WEEKS = 2'd1;
    localparam logic [UNIT_W-1:0] UNIT_YEARS = 2'd2;
    localparam logic [UNIT_W-1:0] UNIT_NONE  = 2'd3;

    typedef logic [YEAR_SPAN-1:0] leap_vec_t;
    typedef logic [DN_W-1:0]      dby_tab_t [YEAR_SPAN];

    function automatic leap_vec_t build_leap();
        leap_vec_t v;
        int m4;
        int m100;
        int m400;
        m4   = BASE_YEAR % 4;
        m100 = BASE_YEAR % 100;
        m400 = BASE_YEAR % 400;
        for (int i = 0; i < YEAR_SPAN; i++) begin
            v[i] = (m4 == 0) && ((BASE_YEAR + i < GREG_START) || (m100 != 0) || (m400 == 0));
            m4   = (m4 == 3) ? 0 : m4 + 1;
            m100 = (m100 == 99) ? 0 : m100 + 1;
            m400 = (m400 == 399) ? 0 : m400 + 1;
        end
        return v;
    endfunction

    // days in all years before each span year
    function automatic dby_tab_t build_dby();
        dby_tab_t  t;
        leap_vec_t lv;
        int        acc;
        lv  = build_leap();
        acc = 0;
        for (int i = 0; i < YEAR_SPAN; i++) begin
            t[i] = DN_W'(acc);
            acc  = acc + (lv[i] ? 366 : 365);
        end
        return t;
    endfunction

    function automatic int span_days();
        leap_vec_t lv;
        int        acc;
        lv  = build_leap();
        acc = 0;
        for (int i = 0; i < YEAR_SPAN; i++) begin
            acc = acc + (lv[i] ? 366 : 365);
        end
        return acc;
    endfunction

    localparam leap_vec_t LEAP_TABLE = build_leap();
    localparam dby_tab_t  DBY_TABLE  = build_dby();
    localparam int        MAX_DN     = span_days();

    localparam logic signed [ACC_W-1:0] ACC_ONE  = ACC_W'(1);
    localparam logic signed [ACC_W-1:0] ACC_MAX  = ACC_W'(MAX_DN);
    localparam logic signed [ACC_W-1:0] ACC_OVER = ACC_W'(MAX_DN + 1);
    localparam logic signed [NY_W-1:0]  NY_LAST  = NY_W'(YEAR_SPAN - 1);

    // days before month index k (0 is January)
    function automatic logic [CUM_W-1:0] cum_before(input logic [3:0] k, input logic leap);
        logic [CUM_W-1:0] c;
        case (k)
            4'd0:    c = 9'd0;
            4'd1:    c = 9'd31;
            4'd2:    c = 9'd59;
            4'd3:    c = 9'd90;
            4'd4:    c = 9'd120;
            4'd5:    c = 9'd151;
            4'd6:    c = 9'd181;
            4'd7:    c = 9'd212;
            4'd8:    c = 9'd243;
            4'd9:    c = 9'd273;
            4'd10:   c = 9'd304;
            4'd11:   c = 9'd334;
            default: c = 9'd0;
        endcase
        if (leap && (k >= 4'd2) && (k <= 4'd11)) begin
            c = c + 9'd1;
        end
        return c;
    endfunction

    typedef enum logic [3:0] {
        OP_NONE  = 4'd0,
        OP_START = 4'd1,
        OP_SHIFT = 4'd2,
        OP_YINIT = 4'd3,
        OP_YSTEP = 4'd4,
        OP_YTAKE = 4'd5,
        OP_MSTEP = 4'd6,
        OP_MTAKE = 4'd7,
        OP_NEWYR = 4'd8,
        OP_NEWDN = 4'd9,
        OP_ZDATE = 4'd10,
        OP_CHECK = 4'd11,
        OP_DONE  = 4'd12
    } uop_t;

    typedef enum logic [2:0] {
        C_NEVER   = 3'd0,
        C_ALWAYS  = 3'd1,
        C_YEARS   = 3'd2,
        C_ZERO    = 3'd3,
        C_BITS    = 3'd4,
        C_FINAL   = 3'd5,
        C_INRANGE = 3'd6
    } cond_t;

    localparam int UPC_W = 4;

    typedef struct packed {
        uop_t             op;
        cond_t            cond;
        logic [UPC_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic load;
        uop_t op;
    } ctrl_t;

    typedef struct packed {
        logic years;
        logic zero;
        logic bits_left;
        logic fin;
        logic in_range;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

@@ sv/ddau_useq.sv @@
`default_nettype none

module ddau_useq import ddau_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_tvalid,
    output logic       s_tready,
    input  wire stat_t stat,
    output ctrl_t      ctrl
);

    localparam logic [UPC_W-1:0] A_START = 4'd0;
    localparam logic [UPC_W-1:0] A_SHIFT = 4'd1;
    localparam logic [UPC_W-1:0] A_YINIT = 4'd2;
    localparam logic [UPC_W-1:0] A_YSTEP = 4'd3;
    localparam logic [UPC_W-1:0] A_YTAKE = 4'd4;
    localparam logic [UPC_W-1:0] A_MSTEP = 4'd5;
    localparam logic [UPC_W-1:0] A_MTAKE = 4'd6;
    localparam logic [UPC_W-1:0] A_NEWYR = 4'd7;
    localparam logic [UPC_W-1:0] A_NEWDN = 4'd8;
    localparam logic [UPC_W-1:0] A_ZDATE = 4'd9;
    localparam logic [UPC_W-1:0] A_CHECK = 4'd10;
    localparam logic [UPC_W-1:0] A_DONE  = 4'd11;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } seq_state_t;

    // control store
    function automatic uword_t ucode_at(input logic [UPC_W-1:0] a);
        uword_t w;
        unique case (a)
            A_START: w = '{OP_START, C_YEARS,   A_YINIT};
            A_SHIFT: w = '{OP_SHIFT, C_ALWAYS,  A_CHECK};
            A_YINIT: w = '{OP_YINIT, C_ZERO,    A_ZDATE};
            A_YSTEP: w = '{OP_YSTEP, C_BITS,    A_YSTEP};
            A_YTAKE: w = '{OP_YTAKE, C_NEVER,   A_START};
            A_MSTEP: w = '{OP_MSTEP, C_BITS,    A_MSTEP};
            A_MTAKE: w = '{OP_MTAKE, C_FINAL,   A_DONE};
            A_NEWYR: w = '{OP_NEWYR, C_NEVER,   A_START};
            A_NEWDN: w = '{OP_NEWDN, C_ALWAYS,  A_CHECK};
            A_ZDATE: w = '{OP_ZDATE, C_ALWAYS,  A_NEWYR};
            A_CHECK: w = '{OP_CHECK, C_INRANGE, A_YINIT};
            A_DONE:  w = '{OP_DONE,  C_NEVER,   A_START};
            default: w = '{OP_NONE,  C_ALWAYS,  A_DONE};
        endcase
        return w;
    endfunction

    seq_state_t       state_reg, state_next;
    logic [UPC_W-1:0] upc_reg, upc_next;
    uword_t           cw;
    logic             taken;
    logic             stall;
    logic             accept;

    assign cw       = ucode_at(upc_reg);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign stall    = (cw.op == OP_DONE) && !stat.out_free;

    always_comb begin
        case (cw.cond)
            C_NEVER:   taken = 1'b0;
            C_ALWAYS:  taken = 1'b1;
            C_YEARS:   taken = stat.years;
            C_ZERO:    taken = stat.zero;
            C_BITS:    taken = stat.bits_left;
            C_FINAL:   taken = stat.fin;
            C_INRANGE: taken = stat.in_range;
            default:   taken = 1'b0;
        endcase
    end

    always_comb begin
        ctrl.load  = accept;
        ctrl.op    = OP_NONE;
        state_next = state_reg;
        upc_next   = upc_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_RUN;
                    upc_next   = A_START;
                end
            end
            ST_RUN: begin
                if (!stall) begin
                    ctrl.op = cw.op;
                    if (cw.op == OP_DONE) begin
                        state_next = ST_IDLE;
                    end else if (taken) begin
                        upc_next = cw.target;
                    end else begin
                        upc_next = upc_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            upc_reg   <= A_START;
        end else begin
            state_reg <= state_next;
            upc_reg   <= upc_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/ddau_datapath.sv @@
`default_nettype none

module ddau_datapath import ddau_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire ctrl_t                 ctrl,
    output stat_t                      stat,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic [UNIT_W-1:0]     s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,
    output logic [0:0]                 m_tuser
);

    // input fields
    logic [DAY_W-1:0]  in_day;
    logic [MON_W-1:0]  in_month;
    logic [YEAR_W-1:0] in_year;
    logic [YOFF_W-1:0] in_yoff;
    logic [3:0]        in_midx;

    assign in_day   = s_tdata[DAY_LSB +: DAY_W];
    assign in_month = s_tdata[MON_LSB +: MON_W];
    assign in_year  = s_tdata[YEAR_LSB +: YEAR_W];

    always_comb begin
        if (in_year < FIRST_YEAR) begin
            in_yoff = '0;
        end else if (in_year > LAST_YEAR) begin
            in_yoff = YOFF_W'(YEAR_SPAN - 1);
        end else begin
            in_yoff = YOFF_W'(in_year - FIRST_YEAR);
        end
        if (in_month == MON_W'(0)) begin
            in_midx = 4'd0;
        end else if (in_month > MON_W'(12)) begin
            in_midx = 4'd11;
        end else begin
            in_midx = in_month - 4'd1;
        end
    end

    // captured item
    logic [DAY_W-1:0]  day_reg;
    logic [3:0]        midx_reg;
    logic [YOFF_W-1:0] yoff_reg;
    logic              sub_reg;
    logic [AMT_W-1:0]  amt_reg;
    logic [UNIT_W-1:0] unit_reg;

    // working registers
    logic [DN_W-1:0]          start_reg, start_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic [SRCH_W-1:0]        idx_reg, idx_next;
    logic [BIT_W-1:0]         bit_reg, bit_next;
    logic signed [YOFF_W:0]   ryear_reg, ryear_next;
    logic [3:0]               rmon_reg, rmon_next;
    logic [DAY_W-1:0]         rday_reg, rday_next;
    logic signed [NY_W-1:0]   ny_reg, ny_next;
    logic                     oor_reg, oor_next;
    logic                     fin_reg, fin_next;

    // result register
    logic                     out_valid_reg, out_valid_next;
    logic [DN_W-1:0]          out_dn_reg, out_dn_next;
    logic [DAY_W-1:0]         out_day_reg, out_day_next;
    logic [MON_W-1:0]         out_mon_reg, out_mon_next;
    logic [YEAR_W-1:0]        out_year_reg, out_year_next;
    logic                     out_oor_reg, out_oor_next;

    // datapath terms
    logic                     leap_in, leap_res, leap_ny;
    logic [YOFF_W-1:0]        ry_idx, ny_idx;
    logic [DN_W-1:0]          start_sum;
    logic [ACC_W-1:0]         start_ext;
    logic [AMT_W+2:0]         step_w;
    logic signed [ACC_W-1:0]  shift_val;
    logic [ACC_W-1:0]         acc_u;
    logic [SRCH_W-1:0]        ycand;
    logic                     year_ok;
    logic [3:0]               mcand;
    logic                     mon_ok;
    logic [ACC_W-1:0]         mrem;
    logic signed [NY_W-1:0]   ry_ext;
    logic [NY_W-1:0]          amt_ext;
    logic [ACC_W-1:0]         ny_sum;
    logic                     ny_low, ny_high;
    logic                     acc_lt, acc_gt, in_range;
    logic                     out_free;

    assign leap_in   = LEAP_TABLE[yoff_reg];
    assign ry_idx    = ryear_reg[YOFF_W-1:0];
    assign leap_res  = LEAP_TABLE[ry_idx];
    assign ny_idx    = ny_reg[YOFF_W-1:0];
    assign leap_ny   = LEAP_TABLE[ny_idx];

    assign start_sum = DBY_TABLE[yoff_reg] + DN_W'(cum_before(midx_reg, leap_in))
                     + DN_W'(day_reg);
    assign start_ext = ACC_W'(start_reg);

    // weeks: amount * 7 as (amount << 3) - amount
    assign step_w = (unit_reg == UNIT_WEEKS) ? ({amt_reg, 3'b000} - {3'b000, amt_reg})
                                             : {3'b000, amt_reg};

    always_comb begin
        if (unit_reg == UNIT_NONE) begin
            shift_val = start_ext;
        end else if (sub_reg) begin
            shift_val = start_ext - ACC_W'(step_w);
        end else begin
            shift_val = start_ext + ACC_W'(step_w);
        end
    end

    assign acc_u   = acc_reg;

    // year search: largest year whose start lies below the day count
    assign ycand   = idx_reg | (SRCH_W'(1) << bit_reg);
    assign year_ok = (int'(ycand) < YEAR_SPAN)
                  && (ACC_W'(DBY_TABLE[ycand[YOFF_W-1:0]]) < acc_u);

    // month search within the found year
    assign mcand   = idx_reg[3:0] | (4'd1 << bit_reg);
    assign mon_ok  = (mcand < 4'd12) && (ACC_W'(cum_before(mcand, leap_res)) < acc_u);
    assign mrem    = acc_u - ACC_W'(cum_before(idx_reg[3:0], leap_res));

    assign ry_ext  = {{(NY_W-YOFF_W-1){ryear_reg[YOFF_W]}}, ryear_reg};
    assign amt_ext = {{(NY_W-AMT_W){1'b0}}, amt_reg};
    assign ny_sum  = ACC_W'(DBY_TABLE[ny_idx]) + ACC_W'(cum_before(rmon_reg - 4'd1, leap_ny))
                   + ACC_W'(rday_reg);
    assign ny_low  = ny_reg[NY_W-1];
    assign ny_high = !ny_low && (ny_reg > NY_LAST);

    assign acc_lt   = acc_reg < ACC_ONE;
    assign acc_gt   = acc_reg > ACC_MAX;
    assign in_range = !acc_lt && !acc_gt;
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        stat.years     = (unit_reg == UNIT_YEARS);
        stat.zero      = (acc_reg == '0);
        stat.bits_left = (bit_reg != '0);
        stat.fin       = fin_reg;
        stat.in_range  = in_range;
        stat.out_free  = out_free;
    end

    always_comb begin
        start_next     = start_reg;
        acc_next       = acc_reg;
        idx_next       = idx_reg;
        bit_next       = bit_reg;
        ryear_next     = ryear_reg;
        rmon_next      = rmon_reg;
        rday_next      = rday_reg;
        ny_next        = ny_reg;
        oor_next       = oor_reg;
        fin_next       = fin_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_dn_next    = out_dn_reg;
        out_day_next   = out_day_reg;
        out_mon_next   = out_mon_reg;
        out_year_next  = out_year_reg;
        out_oor_next   = out_oor_reg;
        unique case (ctrl.op)
            OP_NONE: begin
            end
            OP_START: begin
                start_next = start_sum;
                acc_next   = ACC_W'(start_sum);
                fin_next   = 1'b0;
            end
            OP_SHIFT: begin
                acc_next = shift_val;
            end
            OP_YINIT: begin
                idx_next = '0;
                bit_next = BIT_W'(YOFF_W - 1);
            end
            OP_YSTEP: begin
                if (year_ok) begin
                    idx_next = ycand;
                end
                bit_next = bit_reg - 1'b1;
            end
            OP_YTAKE: begin
                acc_next   = acc_u - ACC_W'(DBY_TABLE[idx_reg[YOFF_W-1:0]]);
                ryear_next = {1'b0, idx_reg[YOFF_W-1:0]};
                idx_next   = '0;
                bit_next   = BIT_W'(3);
            end
            OP_MSTEP: begin
                if (mon_ok) begin
                    idx_next = SRCH_W'(mcand);
                end
                bit_next = bit_reg - 1'b1;
            end
            OP_MTAKE: begin
                rday_next = DAY_W'(mrem);
                rmon_next = idx_reg[3:0] + 4'd1;
            end
            OP_NEWYR: begin
                ny_next = sub_reg ? (ry_ext - amt_ext) : (ry_ext + amt_ext);
            end
            OP_NEWDN: begin
                if (ny_low) begin
                    acc_next = '0;
                end else if (ny_high) begin
                    acc_next = ACC_OVER;
                end else begin
                    acc_next = ny_sum;
                end
            end
            OP_ZDATE: begin
                // day 0: 31 December of the year before the span
                ryear_next = '1;
                rmon_next  = 4'd12;
                rday_next  = DAY_W'(31);
            end
            OP_CHECK: begin
                fin_next = 1'b1;
                oor_next = !in_range;
                if (acc_lt) begin
                    ryear_next = '0;
                    rmon_next  = 4'd1;
                    rday_next  = DAY_W'(1);
                end else if (acc_gt) begin
                    ryear_next = (YOFF_W+1)'(YEAR_SPAN - 1);
                    rmon_next  = 4'd12;
                    rday_next  = DAY_W'(31);
                end
            end
            OP_DONE: begin
                out_valid_next = 1'b1;
                out_dn_next    = start_reg;
                out_day_next   = rday_reg;
                out_mon_next   = rmon_reg;
                out_year_next  = FIRST_YEAR + YEAR_W'(ry_idx);
                out_oor_next   = oor_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            day_reg  <= in_day;
            midx_reg <= in_midx;
            yoff_reg <= in_yoff;
            sub_reg  <= s_tdata[SUB_LSB];
            amt_reg  <= s_tdata[AMT_LSB +: AMT_W];
            unit_reg <= s_tuser;
        end
        start_reg    <= start_next;
        acc_reg      <= acc_next;
        idx_reg      <= idx_next;
        bit_reg      <= bit_next;
        ryear_reg    <= ryear_next;
        rmon_reg     <= rmon_next;
        rday_reg     <= rday_next;
        ny_reg       <= ny_next;
        oor_reg      <= oor_next;
        out_dn_reg   <= out_dn_next;
        out_day_reg  <= out_day_next;
        out_mon_reg  <= out_mon_next;
        out_year_reg <= out_year_next;
        out_oor_reg  <= out_oor_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            fin_reg       <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            fin_reg       <= fin_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-NYEAR_LSB-YEAR_W){1'b0}},
                       out_year_reg, out_mon_reg, out_day_reg, out_dn_reg};
    assign m_tuser  = out_oor_reg;

endmodule

`default_nettype wire

@@ sv/date_day_number_arithmetic_unit.sv @@
// Gregorian date shifter, day 1 is 1 January 1900, years 1900..2155.
// Input channel s_*: one item holds a start date, a direction, an amount and a
// unit (s_tuser: 0 days, 1 weeks, 2 years). Month and year are clamped first.
// Result channel m_*: the start's day number and the shifted date; m_tuser
// flags a result outside the span, with the date saturated to the nearer span end.
// One item is worked on at a time by a small microcoded sequencer: year
// lookup is an 8-step binary search over a day-count table, month lookup a
// 4-step search.
// A day or week shift forms the start day number, shifts and range-checks it,
// then decodes year and month if in range. A year shift first decodes the
// start day number (day 0 directly), then forms, checks and decodes the new one.
// s_tready is high whenever no item is in work, so the next item is taken the
// cycle after the previous result is loaded into the output register.
// A stalled receiver holds the result in the output register; the block
// finishes the item in work and then waits for the register to drain.
// Reset (aresetn low, synchronous) drops any item in work and empties the
// output register; no clearing pass follows.
`default_nettype none

module date_day_number_arithmetic_unit import ddau_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // in_day, in_month, in_year, subtract, amount, zero pad
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // unit
    input  wire logic [UNIT_W-1:0]     s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // start_day_number, new_day, new_month, new_year, zero pad
    output logic [M_TDATA_W-1:0]       m_tdata,
    // out_of_range
    output logic [0:0]                 m_tuser
);

    ctrl_t ctrl;
    stat_t stat;

    ddau_useq u_useq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    ddau_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

@@ sv/ddau_checker.sv @@
`default_nettype none

`include "date_day_number_arithmetic_unit_assert.svh"

module ddau_checker import ddau_pkg::*; (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [S_TDATA_W-1:0]  s_tdata,
    input wire logic [UNIT_W-1:0]     s_tuser,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [M_TDATA_W-1:0]  m_tdata,
    input wire logic [0:0]            m_tuser
);

    logic [DAY_W-1:0]  o_day;
    logic [MON_W-1:0]  o_mon;
    logic [YEAR_W-1:0] o_year;
    logic              sat_low, sat_high;

    assign o_day    = m_tdata[NDAY_LSB +: DAY_W];
    assign o_mon    = m_tdata[NMON_LSB +: MON_W];
    assign o_year   = m_tdata[NYEAR_LSB +: YEAR_W];
    assign sat_low  = (o_day == DAY_W'(1)) && (o_mon == MON_W'(1)) && (o_year == FIRST_YEAR);
    assign sat_high = (o_day == DAY_W'(31)) && (o_mon == MON_W'(12)) && (o_year == LAST_YEAR);

    `DDAU_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `DDAU_ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `DDAU_ASSERT_RESET(a_reset_idle, aclk, aresetn, s_tready && !m_tvalid)
    `DDAU_ASSERT_NOW(a_saturate, aclk, aresetn, m_tvalid && m_tuser[0], sat_low || sat_high)
    `DDAU_ASSERT_NOW(a_valid_date, aclk, aresetn, m_tvalid && !m_tuser[0], (o_day != '0) && (o_mon != '0) && (o_mon <= MON_W'(12)))

    // unused by the checks, kept for a full port view
    logic unused_in;
    assign unused_in = ^{s_tdata, s_tuser};

endmodule

bind date_day_number_arithmetic_unit ddau_checker u_ddau_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
